// ===== rtl/ffq_pkg.sv =====
package ffq_pkg;

    // queue geometry
    localparam int QUEUE_SLOTS     = 16;
    localparam int FRAME_BYTES_MAX = 64;

    // derived widths
    localparam int SLOT_W  = $clog2(QUEUE_SLOTS);
    localparam int COUNT_W = $clog2(QUEUE_SLOTS + 1);
    localparam int ADDR_W  = $clog2(QUEUE_SLOTS * FRAME_BYTES_MAX);

    // field widths
    localparam int OP_W     = 3;
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 7;
    localparam int STATUS_W = 3;
    localparam int DISC_W   = 5;

    // stream bus widths
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 4;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 3'd0,
        OP_PEEK  = 3'd1,
        OP_POP   = 3'd2,
        OP_TAKE  = 3'd3,
        OP_CLEAR = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 3'd0,
        STS_EMPTY     = 3'd1,
        STS_FULL      = 3'd2,
        STS_TOO_LARGE = 3'd3,
        STS_TOO_SMALL = 3'd4
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_STREAM
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic load_byte;
    } ffq_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic start_stream;
        logic last_load;
    } ffq_stat_t;

    // next slot around the ring
    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] r;
        if (s == SLOT_W'(QUEUE_SLOTS - 1)) begin
            r = '0;
        end else begin
            r = s + 1'b1;
        end
        return r;
    endfunction

endpackage

// ===== rtl/ffq_ctrl.sv =====
module ffq_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  ffq_pkg::ffq_stat_t stat,
    output ffq_pkg::ffq_cmd_t  cmd
);

    ffq_pkg::state_t state_reg;
    ffq_pkg::state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ffq_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ffq_pkg::ST_IDLE: begin
                if (s_axis_tvalid && stat.out_free && stat.start_stream) begin
                    state_next = ffq_pkg::ST_STREAM;
                end
            end
            ffq_pkg::ST_STREAM: begin
                if (stat.out_free && stat.last_load) begin
                    state_next = ffq_pkg::ST_IDLE;
                end
            end
            default: state_next = ffq_pkg::ST_IDLE;
        endcase
    end

    // commands, no transaction taken while reset is held
    always_comb begin
        s_axis_tready = 1'b0;
        cmd           = '0;
        unique case (state_reg)
            ffq_pkg::ST_IDLE: begin
                s_axis_tready = aresetn && stat.out_free;
                cmd.accept    = aresetn && s_axis_tvalid && stat.out_free;
            end
            ffq_pkg::ST_STREAM: begin
                cmd.load_byte = stat.out_free;
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/ffq_datapath.sv =====
module ffq_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [ffq_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    input  logic [ffq_pkg::S_TUSER_W-1:0]     s_axis_tuser,
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [ffq_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    output logic [ffq_pkg::M_TUSER_W-1:0]     m_axis_tuser,
    output logic                              m_axis_tlast,
    input  ffq_pkg::ffq_cmd_t                 cmd,
    output ffq_pkg::ffq_stat_t                stat
);

    localparam int DEPTH = ffq_pkg::QUEUE_SLOTS * ffq_pkg::FRAME_BYTES_MAX;
    localparam logic [ffq_pkg::ADDR_W-1:0] FRAME_STRIDE =
        ffq_pkg::ADDR_W'(ffq_pkg::FRAME_BYTES_MAX);
    localparam logic [ffq_pkg::LEN_W-1:0] LEN_MAX = ffq_pkg::LEN_W'(ffq_pkg::FRAME_BYTES_MAX);
    localparam logic [ffq_pkg::COUNT_W-1:0] COUNT_MAX =
        ffq_pkg::COUNT_W'(ffq_pkg::QUEUE_SLOTS);

    // storage
    logic [ffq_pkg::BYTE_W-1:0] slot_mem [DEPTH];
    logic [ffq_pkg::LEN_W-1:0]  len_mem  [ffq_pkg::QUEUE_SLOTS];
    logic [ffq_pkg::BYTE_W-1:0] mem_q;

    // queue state
    logic [ffq_pkg::SLOT_W-1:0]  head_reg, head_next;
    logic [ffq_pkg::SLOT_W-1:0]  tail_reg, tail_next;
    logic [ffq_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [ffq_pkg::LEN_W-1:0]   woff_reg, woff_next;
    logic                        full_reg, full_next;
    logic                        over_reg, over_next;

    // stream state
    logic [ffq_pkg::ADDR_W-1:0]  rd_addr_reg, rd_addr_next;
    logic [ffq_pkg::LEN_W-1:0]   cnt_reg, cnt_next;
    logic [ffq_pkg::LEN_W-1:0]   slen_reg, slen_next;
    logic                        take_reg, take_next;

    // output register
    logic                          ovalid_reg, ovalid_next;
    ffq_pkg::status_t              ostatus_reg, ostatus_next;
    logic                          obv_reg, obv_next;
    logic [ffq_pkg::BYTE_W-1:0]    obyte_reg, obyte_next;
    logic [ffq_pkg::LEN_W-1:0]     olen_reg, olen_next;
    logic [ffq_pkg::DISC_W-1:0]    odisc_reg, odisc_next;
    logic                          olast_reg, olast_next;

    // input decode
    ffq_pkg::op_t                op;
    logic [ffq_pkg::BYTE_W-1:0]  in_byte;
    logic [ffq_pkg::LEN_W-1:0]   in_cap;
    logic [ffq_pkg::LEN_W-1:0]   head_len;
    logic                        full_now, over_now, store_byte;
    logic [ffq_pkg::ADDR_W-1:0]  wr_addr, head_base;
    logic                        commit;

    assign op       = ffq_pkg::op_t'(s_axis_tuser);
    assign in_byte  = s_axis_tdata[7:0];
    assign in_cap   = s_axis_tdata[14:8];
    assign head_len = len_mem[head_reg];

    assign full_now   = full_reg || (count_reg >= COUNT_MAX);
    assign over_now   = over_reg || (woff_reg >= LEN_MAX);
    assign store_byte = cmd.accept && (op == ffq_pkg::OP_PUSH) && !full_now && !over_now;
    assign commit     = cmd.accept && (op == ffq_pkg::OP_PUSH) && s_axis_tlast
                        && !full_now && !over_now;

    assign wr_addr   = ffq_pkg::ADDR_W'(tail_reg) * FRAME_STRIDE + ffq_pkg::ADDR_W'(woff_reg);
    assign head_base = ffq_pkg::ADDR_W'(head_reg) * FRAME_STRIDE;

    // status toward the controller
    assign stat.out_free     = !ovalid_reg || m_axis_tready;
    assign stat.start_stream = ((op == ffq_pkg::OP_PEEK) || (op == ffq_pkg::OP_TAKE))
                               && (count_reg != '0) && (in_cap >= head_len)
                               && (head_len != '0);
    assign stat.last_load    = (cnt_reg + 1'b1) == slen_reg;

    // byte memory, read from the next read address so mem_q follows rd_addr_reg
    always_ff @(posedge aclk) begin
        if (store_byte) begin
            slot_mem[wr_addr] <= in_byte;
        end
        mem_q <= slot_mem[rd_addr_next];
    end

    // frame length table
    always_ff @(posedge aclk) begin
        if (commit) begin
            len_mem[tail_reg] <= woff_reg + 1'b1;
        end
    end

    // next-state logic for queue, stream and output register
    always_comb begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        woff_next    = woff_reg;
        full_next    = full_reg;
        over_next    = over_reg;
        rd_addr_next = rd_addr_reg;
        cnt_next     = cnt_reg;
        slen_next    = slen_reg;
        take_next    = take_reg;
        ovalid_next  = ovalid_reg && !m_axis_tready;
        ostatus_next = ostatus_reg;
        obv_next     = obv_reg;
        obyte_next   = obyte_reg;
        olen_next    = olen_reg;
        odisc_next   = odisc_reg;
        olast_next   = olast_reg;

        if (cmd.accept) begin
            // default single result fields
            ostatus_next = ffq_pkg::STS_OK;
            obv_next     = 1'b0;
            obyte_next   = '0;
            olen_next    = '0;
            odisc_next   = '0;
            olast_next   = 1'b1;
            unique case (op)
                ffq_pkg::OP_PUSH: begin
                    full_next = full_now;
                    over_next = over_now;
                    if (store_byte) begin
                        woff_next = woff_reg + 1'b1;
                    end
                    if (s_axis_tlast) begin
                        ovalid_next = 1'b1;
                        if (over_now) begin
                            ostatus_next = ffq_pkg::STS_TOO_LARGE;
                        end else if (full_now) begin
                            ostatus_next = ffq_pkg::STS_FULL;
                        end else begin
                            tail_next  = ffq_pkg::slot_inc(tail_reg);
                            count_next = count_reg + 1'b1;
                        end
                        woff_next = '0;
                        full_next = 1'b0;
                        over_next = 1'b0;
                    end
                end
                ffq_pkg::OP_PEEK, ffq_pkg::OP_TAKE: begin
                    if (count_reg == '0) begin
                        ovalid_next  = 1'b1;
                        ostatus_next = ffq_pkg::STS_EMPTY;
                    end else if (in_cap < head_len) begin
                        ovalid_next  = 1'b1;
                        ostatus_next = ffq_pkg::STS_TOO_SMALL;
                        olen_next    = head_len;
                    end else if (head_len == '0) begin
                        // empty frame: single ok result
                        ovalid_next = 1'b1;
                        if (op == ffq_pkg::OP_TAKE) begin
                            head_next  = ffq_pkg::slot_inc(head_reg);
                            count_next = count_reg - 1'b1;
                        end
                    end else begin
                        rd_addr_next = head_base;
                        cnt_next     = '0;
                        slen_next    = head_len;
                        take_next    = (op == ffq_pkg::OP_TAKE);
                    end
                end
                ffq_pkg::OP_POP: begin
                    ovalid_next = 1'b1;
                    if (count_reg == '0) begin
                        ostatus_next = ffq_pkg::STS_EMPTY;
                    end else begin
                        head_next  = ffq_pkg::slot_inc(head_reg);
                        count_next = count_reg - 1'b1;
                    end
                end
                ffq_pkg::OP_CLEAR: begin
                    ovalid_next = 1'b1;
                    odisc_next  = ffq_pkg::DISC_W'(count_reg);
                    head_next   = '0;
                    tail_next   = '0;
                    count_next  = '0;
                    woff_next   = '0;
                    full_next   = 1'b0;
                    over_next   = 1'b0;
                end
                default: begin
                    // unused operation codes give no result
                    ovalid_next = ovalid_reg && !m_axis_tready;
                end
            endcase
        end

        // stream one frame byte
        if (cmd.load_byte) begin
            ovalid_next  = 1'b1;
            ostatus_next = ffq_pkg::STS_OK;
            obv_next     = 1'b1;
            obyte_next   = mem_q;
            olen_next    = slen_reg;
            odisc_next   = '0;
            olast_next   = stat.last_load;
            cnt_next     = cnt_reg + 1'b1;
            rd_addr_next = rd_addr_reg + 1'b1;
            if (stat.last_load && take_reg) begin
                head_next  = ffq_pkg::slot_inc(head_reg);
                count_next = count_reg - 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            woff_reg   <= '0;
            full_reg   <= 1'b0;
            over_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end else begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            woff_reg   <= woff_next;
            full_reg   <= full_next;
            over_reg   <= over_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        rd_addr_reg <= rd_addr_next;
        cnt_reg     <= cnt_next;
        slen_reg    <= slen_next;
        take_reg    <= take_next;
        ostatus_reg <= ostatus_next;
        obv_reg     <= obv_next;
        obyte_reg   <= obyte_next;
        olen_reg    <= olen_next;
        odisc_reg   <= odisc_next;
        olast_reg   <= olast_next;
    end

    // result channel
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {4'b0000, odisc_reg, olen_reg, obyte_reg};
    assign m_axis_tuser  = {obv_reg, ostatus_reg};
    assign m_axis_tlast  = olast_reg;

    // frame count stays within the ring
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_MAX)
        else $error("frame count exceeds slot count");

    // empty ring has head and tail together
    a_empty_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (head_reg == tail_reg))
        else $error("empty queue with head and tail apart");

    // open frame never grows past the slot size
    a_woff_range: assert property (@(posedge aclk) disable iff (!aresetn)
        woff_reg <= LEN_MAX)
        else $error("write offset past slot size");

    // streaming never runs past the frame length
    a_stream_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_byte |-> (cnt_reg < slen_reg))
        else $error("stream index past frame length");

    // an accepted streaming request clears the byte index and holds off further input
    a_stream_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && stat.start_stream) |=> (cnt_reg == '0) && !cmd.accept)
        else $error("stream did not start cleanly");

endmodule

// ===== rtl/frame_fifo_queue.sv =====
// frame_fifo_queue: ring of frame slots fed and drained over stream channels
//
// input channel s_axis: one transaction per operation. tuser carries the
// operation (push byte, peek, pop, take, clear), tlast marks the last byte of
// a pushed frame, tdata carries the byte and the receiver capacity.
// result channel m_axis: push of a last byte, pop, clear and short peek/take
// answers give one transaction; a peek or take that fits streams the frame,
// one transaction per byte, with tlast on the final one.
// a result is registered in the output register on the clock edge that
// takes its input transaction; a peek or take that streams loads the read
// address and the registered byte memory read, then the stream state moves
// each byte into the output register. pushes and single-result operations
// are taken back to back while the output register can move.
// reset clears the ring pointers, frame count and open push; stored bytes
// are not cleared and need no clearing pass.
// when m_axis_tready is low the output register holds its transaction, the
// stream pauses in place and s_axis_tready drops until it can move again.
module frame_fifo_queue (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [7:0] data_byte, [14:8] dest_capacity, [15] zero
    input  logic [ffq_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [2:0] operation
    input  logic [ffq_pkg::S_TUSER_W-1:0] s_axis_tuser,
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [7:0] out_byte, [14:8] frame_length, [19:15] discarded_count, [23:20] zero
    output logic [ffq_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // [2:0] status, [3] byte_valid
    output logic [ffq_pkg::M_TUSER_W-1:0] m_axis_tuser,
    output logic                          m_axis_tlast
);

    ffq_pkg::ffq_cmd_t  cmd;
    ffq_pkg::ffq_stat_t stat;

    // sequencer
    ffq_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    // storage, pointers and output register
    ffq_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule

// ===== bench/frame_fifo_queue_tb.sv =====
`timescale 1ns / 100ps

module frame_fifo_queue_tb;

    // operation codes the block ignores
    localparam logic [ffq_pkg::OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [ffq_pkg::OP_W-1:0] OP_SPARE_LAST  = 3'd7;

    localparam int RANDOM_ITEMS = 420;
    localparam int SCRIPT_ROWS  = 23;
    localparam int DRAIN_GUARD  = 20000;

    // one result transaction, as the block should present it
    typedef struct packed {
        logic [ffq_pkg::STATUS_W-1:0] status;
        logic                         byte_valid;
        logic [ffq_pkg::BYTE_W-1:0]   out_byte;
        logic [ffq_pkg::LEN_W-1:0]    frame_length;
        logic [ffq_pkg::DISC_W-1:0]   discarded;
        logic                         last;
    } answer_t;

    // one row of the directed script; w_* only count when typed is set
    typedef struct packed {
        logic [ffq_pkg::OP_W-1:0]     op;
        logic [ffq_pkg::BYTE_W-1:0]   data;
        logic                         fend;
        logic [ffq_pkg::LEN_W-1:0]    cap;
        logic                         typed;
        logic [ffq_pkg::STATUS_W-1:0] w_status;
        logic [ffq_pkg::LEN_W-1:0]    w_len;
        logic [ffq_pkg::DISC_W-1:0]   w_disc;
    } row_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [ffq_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [ffq_pkg::S_TUSER_W-1:0] s_axis_tuser = '0;
    logic                          s_axis_tlast = 1'b0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [ffq_pkg::M_TDATA_W-1:0] m_axis_tdata;
    logic [ffq_pkg::M_TUSER_W-1:0] m_axis_tuser;
    logic                          m_axis_tlast;

    frame_fifo_queue i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // shadow copy of the ring
    logic [ffq_pkg::BYTE_W-1:0] ring_bytes [ffq_pkg::QUEUE_SLOTS][ffq_pkg::FRAME_BYTES_MAX];
    logic [ffq_pkg::LEN_W-1:0]  ring_len   [ffq_pkg::QUEUE_SLOTS];
    int                         ring_head;
    int                         ring_tail;
    int                         ring_count;
    int                         open_offset;
    bit                         open_full;
    bit                         open_oversize;

    answer_t answers_due [$];
    row_t    script [SCRIPT_ROWS];

    int mismatches;
    int items_sent;
    int answers_checked;
    int frames_committed;
    int full_hits;
    int oversize_hits;
    int bytes_streamed;
    bit calm;

    // clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // watchdog
    initial begin
        #5000000;
        $display("timeout at %0t", $time);
        $display("Mismatches found");
        $finish;
    end

    function automatic void queue_answer(input logic [ffq_pkg::STATUS_W-1:0] st,
                                         input logic bv,
                                         input logic [ffq_pkg::BYTE_W-1:0] ob,
                                         input logic [ffq_pkg::LEN_W-1:0] len,
                                         input logic [ffq_pkg::DISC_W-1:0] disc,
                                         input logic last);
        answer_t a;
        a.status       = st;
        a.byte_valid   = bv;
        a.out_byte     = ob;
        a.frame_length = len;
        a.discarded    = disc;
        a.last         = last;
        answers_due.push_back(a);
    endfunction

    function automatic void drop_head_frame();
        ring_head  = (ring_head + 1) % ffq_pkg::QUEUE_SLOTS;
        ring_count = ring_count - 1;
    endfunction

    // advance the shadow ring by one accepted operation, return results queued
    function automatic int ring_apply(input logic [ffq_pkg::OP_W-1:0] op,
                                      input logic [ffq_pkg::BYTE_W-1:0] data,
                                      input logic fend,
                                      input logic [ffq_pkg::LEN_W-1:0] cap);
        int len;
        int produced;
        produced = 0;
        case (op)
            ffq_pkg::OP_PUSH: begin
                if (ring_count >= ffq_pkg::QUEUE_SLOTS) open_full = 1'b1;
                if (open_offset >= ffq_pkg::FRAME_BYTES_MAX) open_oversize = 1'b1;
                if (!open_full && !open_oversize) begin
                    ring_bytes[ring_tail][open_offset] = data;
                    open_offset = open_offset + 1;
                end
                if (fend) begin
                    if (open_oversize) begin
                        queue_answer(ffq_pkg::STS_TOO_LARGE, 1'b0, '0, '0, '0, 1'b1);
                        oversize_hits++;
                    end else if (open_full) begin
                        queue_answer(ffq_pkg::STS_FULL, 1'b0, '0, '0, '0, 1'b1);
                        full_hits++;
                    end else begin
                        ring_len[ring_tail] = ffq_pkg::LEN_W'(open_offset);
                        ring_tail  = (ring_tail + 1) % ffq_pkg::QUEUE_SLOTS;
                        ring_count = ring_count + 1;
                        frames_committed++;
                        queue_answer(ffq_pkg::STS_OK, 1'b0, '0, '0, '0, 1'b1);
                    end
                    open_offset   = 0;
                    open_full     = 1'b0;
                    open_oversize = 1'b0;
                    produced = 1;
                end
            end
            ffq_pkg::OP_PEEK, ffq_pkg::OP_TAKE: begin
                if (ring_count == 0) begin
                    queue_answer(ffq_pkg::STS_EMPTY, 1'b0, '0, '0, '0, 1'b1);
                    produced = 1;
                end else begin
                    len = ring_len[ring_head];
                    if (len > ffq_pkg::FRAME_BYTES_MAX) len = ffq_pkg::FRAME_BYTES_MAX;
                    if (cap < len) begin
                        queue_answer(ffq_pkg::STS_TOO_SMALL, 1'b0, '0,
                                     ffq_pkg::LEN_W'(len), '0, 1'b1);
                        produced = 1;
                    end else begin
                        if (len == 0) begin
                            queue_answer(ffq_pkg::STS_OK, 1'b0, '0, '0, '0, 1'b1);
                            produced = 1;
                        end else begin
                            for (int i = 0; i < len; i++) begin
                                queue_answer(ffq_pkg::STS_OK, 1'b1, ring_bytes[ring_head][i],
                                             ffq_pkg::LEN_W'(len), '0, (i + 1 == len));
                            end
                            produced = len;
                            bytes_streamed += len;
                        end
                        if (op == ffq_pkg::OP_TAKE) drop_head_frame();
                    end
                end
            end
            ffq_pkg::OP_POP: begin
                if (ring_count == 0) begin
                    queue_answer(ffq_pkg::STS_EMPTY, 1'b0, '0, '0, '0, 1'b1);
                end else begin
                    drop_head_frame();
                    queue_answer(ffq_pkg::STS_OK, 1'b0, '0, '0, '0, 1'b1);
                end
                produced = 1;
            end
            ffq_pkg::OP_CLEAR: begin
                queue_answer(ffq_pkg::STS_OK, 1'b0, '0, '0,
                             ffq_pkg::DISC_W'(ring_count), 1'b1);
                ring_head     = 0;
                ring_tail     = 0;
                ring_count    = 0;
                open_offset   = 0;
                open_full     = 1'b0;
                open_oversize = 1'b0;
                produced = 1;
            end
            default: produced = 0;
        endcase
        return produced;
    endfunction

    // drive one input transaction, wait for its acceptance, then predict it
    task automatic send_item(input logic [ffq_pkg::OP_W-1:0] op,
                             input logic [ffq_pkg::BYTE_W-1:0] data,
                             input logic fend,
                             input logic [ffq_pkg::LEN_W-1:0] cap,
                             output int produced);
        // random idle cycles before the transaction
        while (!calm && $urandom_range(99) < 17) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, cap, data};
        s_axis_tuser  <= op;
        s_axis_tlast  <= fend;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        produced = ring_apply(op, data, fend, cap);
        items_sent++;
    endtask

    // hold the sender until every expected result has come back
    task automatic drain_answers();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (answers_due.size() != 0 && guard < DRAIN_GUARD) begin
            @(posedge aclk);
            guard++;
        end
        if (answers_due.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, answers_due.size());
            mismatches++;
            answers_due.delete();
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic push_frame(input int len);
        int n;
        for (int i = 0; i < len; i++) begin
            send_item(ffq_pkg::OP_PUSH, ffq_pkg::BYTE_W'($urandom_range(0, 255)),
                      (i == len - 1), ffq_pkg::LEN_W'($urandom_range(0, 127)), n);
        end
    endtask

    // peek or take with a capacity near the head frame's length or random
    task automatic read_head(input logic [ffq_pkg::OP_W-1:0] op);
        int n;
        int hl;
        logic [ffq_pkg::LEN_W-1:0] cap;
        hl = (ring_count == 0) ? 0 : ring_len[ring_head];
        case ($urandom_range(0, 4))
            0:       cap = ffq_pkg::LEN_W'(hl);
            1:       cap = ffq_pkg::LEN_W'((hl > 0) ? hl - 1 : 0);
            2:       cap = ffq_pkg::LEN_W'($urandom_range(0, 64));
            3:       cap = ffq_pkg::LEN_W'($urandom_range(65, 127));
            default: cap = ffq_pkg::LEN_W'(hl + $urandom_range(0, 3));
        endcase
        send_item(op, ffq_pkg::BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  cap, n);
    endtask

    function automatic row_t row(input logic [ffq_pkg::OP_W-1:0] op,
                                 input logic [ffq_pkg::BYTE_W-1:0] data,
                                 input logic fend,
                                 input logic [ffq_pkg::LEN_W-1:0] cap);
        row_t r;
        r = '0;
        r.op   = op;
        r.data = data;
        r.fend = fend;
        r.cap  = cap;
        return r;
    endfunction

    function automatic row_t row_w(input logic [ffq_pkg::OP_W-1:0] op,
                                   input logic [ffq_pkg::BYTE_W-1:0] data,
                                   input logic fend,
                                   input logic [ffq_pkg::LEN_W-1:0] cap,
                                   input logic [ffq_pkg::STATUS_W-1:0] st,
                                   input logic [ffq_pkg::LEN_W-1:0] len,
                                   input logic [ffq_pkg::DISC_W-1:0] disc);
        row_t r;
        r = row(op, data, fend, cap);
        r.typed    = 1'b1;
        r.w_status = st;
        r.w_len    = len;
        r.w_disc   = disc;
        return r;
    endfunction

    // result sink backpressure
    always @(posedge aclk) begin
        m_axis_tready <= calm || ($urandom_range(99) >= 17);
    end

    // result checker
    always @(posedge aclk) begin
        answer_t want;
        answer_t got;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.status       = m_axis_tuser[2:0];
            got.byte_valid   = m_axis_tuser[3];
            got.out_byte     = m_axis_tdata[7:0];
            got.frame_length = m_axis_tdata[14:8];
            got.discarded    = m_axis_tdata[19:15];
            got.last         = m_axis_tlast;
            if (answers_due.size() == 0) begin
                if (mismatches < 40)
                    $display({"%0t: result with nothing expected: ",
                              "sts %0d bv %0d byte %0h len %0d disc %0d last %0d"},
                             $time, got.status, got.byte_valid, got.out_byte,
                             got.frame_length, got.discarded, got.last);
                mismatches++;
            end else begin
                want = answers_due.pop_front();
                answers_checked++;
                if (got !== want) begin
                    if (mismatches < 40)
                        $display({"%0t: expected sts %0d bv %0d byte %0h len %0d ",
                                  "disc %0d last %0d, actual sts %0d bv %0d byte %0h ",
                                  "len %0d disc %0d last %0d"},
                                 $time, want.status, want.byte_valid, want.out_byte,
                                 want.frame_length, want.discarded, want.last,
                                 got.status, got.byte_valid, got.out_byte,
                                 got.frame_length, got.discarded, got.last);
                    mismatches++;
                end
            end
        end
    end

    // stimulus
    initial begin
        answer_t typed_ans;
        int n;
        int pick;
        mismatches = 0;
        items_sent = 0;
        answers_checked = 0;
        frames_committed = 0;
        full_hits = 0;
        oversize_hits = 0;
        bytes_streamed = 0;
        calm = 1'b0;
        ring_head = 0;
        ring_tail = 0;
        ring_count = 0;
        open_offset = 0;
        open_full = 1'b0;
        open_oversize = 1'b0;

        script = '{
            row_w(ffq_pkg::OP_PEEK,  8'h00, 1'b0, 7'd0,  ffq_pkg::STS_EMPTY, 7'd0, 5'd0),
            row_w(ffq_pkg::OP_POP,   8'h00, 1'b0, 7'd0,  ffq_pkg::STS_EMPTY, 7'd0, 5'd0),
            row_w(ffq_pkg::OP_TAKE,  8'hFF, 1'b1, 7'd64, ffq_pkg::STS_EMPTY, 7'd0, 5'd0),
            row_w(ffq_pkg::OP_CLEAR, 8'h00, 1'b0, 7'd0,  ffq_pkg::STS_OK,    7'd0, 5'd0),
            row  (ffq_pkg::OP_PUSH,  8'h00, 1'b0, 7'd127),
            row_w(ffq_pkg::OP_PUSH,  8'hFF, 1'b1, 7'd0,  ffq_pkg::STS_OK,    7'd0, 5'd0),
            row_w(ffq_pkg::OP_PEEK,  8'h00, 1'b0, 7'd0,  ffq_pkg::STS_TOO_SMALL, 7'd2, 5'd0),
            row_w(ffq_pkg::OP_PEEK,  8'h00, 1'b0, 7'd1,  ffq_pkg::STS_TOO_SMALL, 7'd2, 5'd0),
            row  (ffq_pkg::OP_PEEK,  8'h00, 1'b0, 7'd2),
            row_w(ffq_pkg::OP_PUSH,  8'h80, 1'b1, 7'd64, ffq_pkg::STS_OK,    7'd0, 5'd0),
            row  (ffq_pkg::OP_TAKE,  8'h00, 1'b0, 7'd127),
            row  (OP_SPARE_FIRST,    8'hFF, 1'b1, 7'd127),
            row  (OP_SPARE_LAST,     8'h00, 1'b0, 7'd0),
            row  (ffq_pkg::OP_PEEK,  8'hFF, 1'b1, 7'd64),
            row  (ffq_pkg::OP_PUSH,  8'h55, 1'b0, 7'd0),
            row_w(ffq_pkg::OP_CLEAR, 8'h00, 1'b0, 7'd0,  ffq_pkg::STS_OK,    7'd0, 5'd1),
            row_w(ffq_pkg::OP_PUSH,  8'hAA, 1'b1, 7'd0,  ffq_pkg::STS_OK,    7'd0, 5'd0),
            row  (ffq_pkg::OP_TAKE,  8'h00, 1'b0, 7'd1),
            row_w(ffq_pkg::OP_POP,   8'h00, 1'b0, 7'd0,  ffq_pkg::STS_EMPTY, 7'd0, 5'd0),
            row_w(ffq_pkg::OP_PUSH,  8'h01, 1'b1, 7'd0,  ffq_pkg::STS_OK,    7'd0, 5'd0),
            row_w(ffq_pkg::OP_PUSH,  8'h7F, 1'b1, 7'd0,  ffq_pkg::STS_OK,    7'd0, 5'd0),
            row_w(ffq_pkg::OP_CLEAR, 8'h00, 1'b0, 7'd0,  ffq_pkg::STS_OK,    7'd0, 5'd2),
            row_w(ffq_pkg::OP_TAKE,  8'h00, 1'b0, 7'd0,  ffq_pkg::STS_EMPTY, 7'd0, 5'd0)
        };

        // reset
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed script; typed rows replace the predicted single result
        foreach (script[i]) begin
            send_item(script[i].op, script[i].data, script[i].fend, script[i].cap, n);
            if (script[i].typed) begin
                repeat (n) void'(answers_due.pop_back());
                typed_ans = '0;
                typed_ans.status       = script[i].w_status;
                typed_ans.frame_length = script[i].w_len;
                typed_ans.discarded    = script[i].w_disc;
                typed_ans.last         = 1'b1;
                answers_due.push_back(typed_ans);
            end
        end

        // random sequences, mostly well-formed frames and reads
        while (items_sent < SCRIPT_ROWS + RANDOM_ITEMS) begin
            calm = (items_sent >= 170 && items_sent < 280);
            if (items_sent >= 250 && items_sent < 260) drain_answers();
            pick = $urandom_range(0, 99);
            if (pick < 38) begin
                case ($urandom_range(0, 19))
                    0, 1:    push_frame($urandom_range(9, ffq_pkg::FRAME_BYTES_MAX));
                    2:       push_frame($urandom_range(ffq_pkg::FRAME_BYTES_MAX + 1,
                                                       ffq_pkg::FRAME_BYTES_MAX + 6));
                    default: push_frame($urandom_range(1, 8));
                endcase
            end else if (pick < 60) begin
                read_head(($urandom_range(0, 1) == 0) ? ffq_pkg::OP_PEEK : ffq_pkg::OP_TAKE);
            end else if (pick < 70) begin
                send_item(ffq_pkg::OP_POP, ffq_pkg::BYTE_W'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), ffq_pkg::LEN_W'($urandom_range(0, 127)), n);
            end else if (pick < 73) begin
                send_item(ffq_pkg::OP_CLEAR, ffq_pkg::BYTE_W'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), ffq_pkg::LEN_W'($urandom_range(0, 127)), n);
            end else if (pick < 78) begin
                // broken frame: a few bytes with no end, sometimes abandoned by clear
                for (int i = $urandom_range(1, 5); i > 0; i--) begin
                    send_item(ffq_pkg::OP_PUSH, ffq_pkg::BYTE_W'($urandom_range(0, 255)), 1'b0,
                              ffq_pkg::LEN_W'($urandom_range(0, 127)), n);
                end
                if ($urandom_range(0, 1) == 0) send_item(ffq_pkg::OP_CLEAR, '0, 1'b0, '0, n);
            end else if (pick < 82) begin
                // unused operation code, no result expected
                send_item(ffq_pkg::OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)),
                          ffq_pkg::BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          ffq_pkg::LEN_W'($urandom_range(0, 127)), n);
            end else if (pick < 85) begin
                // fill the ring, then one frame more than it holds
                while (ring_count < ffq_pkg::QUEUE_SLOTS) push_frame($urandom_range(1, 2));
                push_frame($urandom_range(1, 3));
            end else begin
                send_item(ffq_pkg::OP_W'($urandom_range(ffq_pkg::OP_PUSH, ffq_pkg::OP_CLEAR)),
                          ffq_pkg::BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          ffq_pkg::LEN_W'($urandom_range(0, 127)), n);
            end
        end
        calm = 1'b0;

        // wait out the remaining results, then look for strays
        drain_answers();
        repeat (8) @(posedge aclk);

        $display("%0d operations sent, %0d results checked, %0d bytes streamed",
                 items_sent, answers_checked, bytes_streamed);
        $display("%0d frames committed, %0d full and %0d too-large rejections",
                 frames_committed, full_hits, oversize_hits);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
